// ===== src/time_index_range_search_unit_defines.svh =====
// Assertion macros shared by the search unit.
`ifndef TIME_INDEX_RANGE_SEARCH_UNIT_DEFINES_SVH
`define TIME_INDEX_RANGE_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TIRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TIRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tirs_pkg.sv =====
`timescale 1ns / 1ps

package tirs_pkg;

    localparam int SLOT_W    = 12;
    localparam int TIME_BITS = 48;
    localparam int CMD_W     = 2;
    localparam int unsigned DEPTH_DEF = 4096;

    // Command codes of a query word
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FIRST = 2'd1,
        CMD_LAST  = 2'd2
    } tirs_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] time_value;
        logic [SLOT_W-1:0]    first_slot;
        logic [SLOT_W-1:0]    last_slot;
    } tirs_query_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_slot;
    } tirs_answer_t;

    // Table port request from the sequencer
    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_W-1:0]    addr;
        logic [TIME_BITS-1:0] wdata;
    } tirs_mem_req_t;

    // Outcome of the shared comparator
    typedef struct packed {
        logic lt;
        logic gt;
    } tirs_cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_STEP,
        ST_RESULT
    } tirs_state_t;

endpackage

// ===== src/tirs_table.sv =====
`timescale 1ns / 1ps

module tirs_table #(
    parameter int unsigned DEPTH = tirs_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  tirs_pkg::tirs_mem_req_t             req,
    output logic [tirs_pkg::TIME_BITS-1:0]      rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [tirs_pkg::TIME_BITS-1:0] time_mem [DEPTH];
    logic [tirs_pkg::TIME_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]              addr_w;

    assign addr_w = ADDR_W'(req.addr);

    // Write a loaded timestamp, otherwise read one word with registered data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            time_mem[addr_w] <= req.wdata;
        end
        else
        begin
            rd_data_reg <= time_mem[addr_w];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/tirs_cmp.sv =====
`timescale 1ns / 1ps

module tirs_cmp (
    input  logic [tirs_pkg::TIME_BITS-1:0] table_time,
    input  logic [tirs_pkg::TIME_BITS-1:0] asked_time,
    output tirs_pkg::tirs_cmp_t            res
);

    // Order the table word against the asked time
    always_comb
    begin
        res.lt = table_time < asked_time;
        res.gt = table_time > asked_time;
    end

endmodule

// ===== src/tirs_seq.sv =====
`timescale 1ns / 1ps

module tirs_seq #(
    parameter int unsigned DEPTH = tirs_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  tirs_pkg::tirs_query_t           query,
    input  logic [tirs_pkg::TIME_BITS-1:0]  rd_data,
    output tirs_pkg::tirs_mem_req_t         mem_req,
    output logic                            idle,
    output logic                            res_valid,
    input  logic                            res_ready,
    output tirs_pkg::tirs_answer_t          res
);

    localparam int SW = tirs_pkg::SLOT_W;

    tirs_pkg::tirs_state_t          state_reg, state_next;
    logic                           is_first_reg, is_first_next;
    logic [tirs_pkg::TIME_BITS-1:0] time_reg, time_next;
    logic [SW-1:0]                  lo_reg, lo_next;
    logic [SW-1:0]                  hi_reg, hi_next;
    logic [SW-1:0]                  mid_reg, mid_next;
    logic                           found_reg, found_next;
    logic [SW-1:0]                  slot_reg, slot_next;

    tirs_pkg::tirs_cmp_t cmp;
    logic                move_hi;
    logic [SW-1:0]       cur_lo, cur_hi, span, cur_mid;
    logic                span_done;
    logic                range_ok, load_ok;

    tirs_cmp u_cmp (
        .table_time (rd_data),
        .asked_time (time_reg),
        .res        (cmp)
    );

    // Narrow the bounds: the first-at-or-after search keeps equal words on the
    // high side, the last-at-or-before search moves right past them
    assign move_hi = is_first_reg ? !cmp.lt : cmp.gt;
    assign cur_lo  = (state_reg == tirs_pkg::ST_STEP && !move_hi) ? mid_reg : lo_reg;
    assign cur_hi  = (state_reg == tirs_pkg::ST_STEP && move_hi)  ? mid_reg : hi_reg;
    assign span      = cur_hi - cur_lo;
    assign span_done = (span[SW-1:1] == '0);
    assign cur_mid   = cur_lo + (span >> 1);

    assign range_ok = (query.first_slot <= query.last_slot) && (32'(query.last_slot) < DEPTH);
    assign load_ok  = 32'(query.slot) < DEPTH;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tirs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold search operands and the result
    always_ff @(posedge clk)
    begin
        is_first_reg <= is_first_next;
        time_reg     <= time_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
    end

    // Advance the sequencer and steer the table port
    always_comb
    begin
        state_next    = state_reg;
        is_first_next = is_first_reg;
        time_next     = time_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        mem_req.wr_en = 1'b0;
        mem_req.addr  = query.slot;
        mem_req.wdata = query.time_value;

        case (state_reg)
            tirs_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (query.cmd)
                        tirs_pkg::CMD_LOAD:
                        begin
                            mem_req.wr_en = load_ok;
                        end
                        tirs_pkg::CMD_FIRST, tirs_pkg::CMD_LAST:
                        begin
                            is_first_next = (query.cmd == tirs_pkg::CMD_FIRST);
                            time_next     = query.time_value;
                            lo_next       = query.first_slot;
                            hi_next       = query.last_slot;
                            if (range_ok)
                            begin
                                mem_req.addr = (query.cmd == tirs_pkg::CMD_FIRST) ?
                                               query.last_slot : query.first_slot;
                                state_next   = tirs_pkg::ST_FIRST;
                            end
                            else
                            begin
                                found_next = 1'b0;
                                slot_next  = '0;
                                state_next = tirs_pkg::ST_RESULT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Test the far endpoint: report a miss if the time lies outside
            tirs_pkg::ST_FIRST:
            begin
                if (is_first_reg ? cmp.lt : cmp.gt)
                begin
                    found_next = 1'b0;
                    slot_next  = '0;
                    state_next = tirs_pkg::ST_RESULT;
                end
                else
                begin
                    mem_req.addr = is_first_reg ? lo_reg : hi_reg;
                    state_next   = tirs_pkg::ST_SECOND;
                end
            end

            // Test the near endpoint, then start halving
            tirs_pkg::ST_SECOND:
            begin
                if (is_first_reg ? !cmp.lt : !cmp.gt)
                begin
                    found_next = 1'b1;
                    slot_next  = is_first_reg ? lo_reg : hi_reg;
                    state_next = tirs_pkg::ST_RESULT;
                end
                else if (span_done)
                begin
                    found_next = 1'b1;
                    slot_next  = is_first_reg ? cur_hi : cur_lo;
                    state_next = tirs_pkg::ST_RESULT;
                end
                else
                begin
                    mem_req.addr = cur_mid;
                    mid_next     = cur_mid;
                    state_next   = tirs_pkg::ST_STEP;
                end
            end

            // One midpoint per cycle
            tirs_pkg::ST_STEP:
            begin
                lo_next = cur_lo;
                hi_next = cur_hi;
                if (span_done)
                begin
                    found_next = 1'b1;
                    slot_next  = is_first_reg ? cur_hi : cur_lo;
                    state_next = tirs_pkg::ST_RESULT;
                end
                else
                begin
                    mem_req.addr = cur_mid;
                    mid_next     = cur_mid;
                end
            end

            tirs_pkg::ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = tirs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tirs_pkg::ST_IDLE;
            end
        endcase
    end

    assign idle           = (state_reg == tirs_pkg::ST_IDLE);
    assign res_valid      = (state_reg == tirs_pkg::ST_RESULT);
    assign res.found      = found_reg;
    assign res.found_slot = slot_reg;

endmodule

// ===== src/time_index_range_search_unit.sv =====
`timescale 1ns / 1ps
// A load word gives no answer and leaves the unit ready for the next word.
// A search with a valid range tests the far endpoint, then the near one, then one midpoint
// per cycle, ending early once an endpoint decides; it stalls the query side until its
// answer moves into the answer register, which a stalled, full answer register delays.
// Reset (rst_n low, asynchronous) empties the sequencer and the answer register;
// the timestamp table is not cleared and holds no meaning until loaded.

`include "time_index_range_search_unit_defines.svh"

module time_index_range_search_unit #(
    parameter int unsigned DEPTH = tirs_pkg::DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   query_valid,
    output logic                   query_stall,
    input  tirs_pkg::tirs_query_t  query,
    output logic                   answer_valid,
    input  logic                   answer_stall,
    output tirs_pkg::tirs_answer_t answer
);

    tirs_pkg::tirs_mem_req_t        mem_req;
    logic [tirs_pkg::TIME_BITS-1:0] rd_data;
    logic                           seq_idle;
    logic                           res_valid;
    logic                           res_ready;
    tirs_pkg::tirs_answer_t         res;
    logic                           take;
    logic                           take_search;
    logic                           take_load;
    logic                           answer_miss;

    logic                   answer_valid_reg, answer_valid_next;
    tirs_pkg::tirs_answer_t answer_reg, answer_next;

    assign query_stall = !seq_idle;
    assign take        = query_valid && !query_stall;

    tirs_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    tirs_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .query     (query),
        .rd_data   (rd_data),
        .mem_req   (mem_req),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Load the answer register when it is empty or being drained
    assign res_ready = !answer_valid_reg || !answer_stall;

    always_comb
    begin
        answer_valid_next = answer_valid_reg;
        answer_next       = answer_reg;
        if (res_valid && res_ready)
        begin
            answer_valid_next = 1'b1;
            answer_next       = res;
        end
        else if (!answer_stall)
        begin
            answer_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_valid_reg <= 1'b0;
        end
        else
        begin
            answer_valid_reg <= answer_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
    end

    assign answer_valid = answer_valid_reg;
    assign answer       = answer_reg;

    // Classify taken words and answers for the checks below
    assign take_search = take && (query.cmd inside {tirs_pkg::CMD_FIRST, tirs_pkg::CMD_LAST});
    assign take_load   = take && (query.cmd == tirs_pkg::CMD_LOAD);
    assign answer_miss = answer_valid && !answer.found;

    // A search keeps the query side stalled after it is taken
    `TIRS_ASSERT_NEXT(a_search_holds, take_search, query_stall, "search did not occupy the unit")
    // A load leaves the unit ready
    `TIRS_ASSERT_NEXT(a_load_ready, take_load, !query_stall, "load stalled the query side")
    // A miss reports slot zero
    `TIRS_ASSERT_SAME(a_miss_zero, answer_miss, answer.found_slot == '0, "miss with nonzero slot")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tirs_pkg::*;

    localparam int unsigned DEPTH       = DEPTH_DEF;
    localparam int unsigned STIM_TOTAL  = 1650;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [TIME_BITS-1:0] TIME_TOP   = '1;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         query_valid = 1'b0;
    logic         query_stall;
    tirs_query_t  query = '0;
    logic         answer_valid;
    logic         answer_stall = 1'b0;
    tirs_answer_t answer;

    // Timestamps as the unit holds them, updated as words are taken
    logic [TIME_BITS-1:0] stamp_mem [DEPTH];
    // Timestamps as planned by the word generator, and which slots it has loaded
    bit [TIME_BITS-1:0]   plan_time [DEPTH];
    bit                   plan_set  [DEPTH];
    int                   first_gap;

    tirs_query_t  feed_q[$];
    tirs_answer_t answer_due_q[$];
    tirs_answer_t due_answer;

    int unsigned total_count = 0;
    int unsigned taken_count = 0;
    int unsigned error_count = 0;
    int          send_pause;
    bit          send_calm;
    int          hold_left;
    bit          hold_calm;
    int unsigned quiet_cycles = 0;

    time_index_range_search_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .answer_valid (answer_valid),
        .answer_stall (answer_stall),
        .answer       (answer)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Fetch one stored time; on the planning table, note the first slot never loaded
    function automatic logic [TIME_BITS-1:0] stamp_at(bit plan, int unsigned idx);
        if (!plan)
            return stamp_mem[idx];
        if (!plan_set[idx] && first_gap < 0)
            first_gap = idx;
        return plan_time[idx];
    endfunction

    // Binary search for first slot at or after, or last slot at or before, the time
    function automatic tirs_answer_t locate(bit plan, logic [CMD_W-1:0] op,
                                            logic [TIME_BITS-1:0] t,
                                            logic [SLOT_W-1:0] first,
                                            logic [SLOT_W-1:0] last);
        int unsigned lo, hi, mid;
        logic [TIME_BITS-1:0] lo_t, hi_t, mid_t;
        tirs_answer_t res;
        bit done;
        lo   = first;
        hi   = last;
        res  = '0;
        done = (lo > hi) || (hi >= DEPTH);
        while (!done)
        begin
            lo_t = stamp_at(plan, lo);
            hi_t = stamp_at(plan, hi);
            done = 1'b1;
            if (op == CMD_FIRST)
            begin
                if (t > hi_t)
                    res = '0;
                else if (lo_t >= t)
                    res = {1'b1, lo[SLOT_W-1:0]};
                else if (hi - lo <= 1)
                    res = {1'b1, hi[SLOT_W-1:0]};
                else
                    done = 1'b0;
            end
            else
            begin
                if (t < lo_t)
                    res = '0;
                else if (t >= hi_t)
                    res = {1'b1, hi[SLOT_W-1:0]};
                else if (hi - lo <= 1)
                    res = {1'b1, lo[SLOT_W-1:0]};
                else
                    done = 1'b0;
            end
            if (!done)
            begin
                mid   = lo + (hi - lo) / 2;
                mid_t = stamp_at(plan, mid);
                // equal midpoint moves left for a first search, right for a last search
                if ((op == CMD_FIRST) ? (mid_t >= t) : (mid_t > t))
                    hi = mid;
                else
                    lo = mid;
            end
        end
        return res;
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_BITS-1:0];
    endfunction

    function automatic int pick_pause(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pick a time between the nearest loaded neighbours, keeping the table ascending
    function automatic logic [TIME_BITS-1:0] fill_value(int s);
        logic [TIME_BITS-1:0] below, above;
        logic [63:0] span, r;
        below = '0;
        above = TIME_TOP;
        for (int i = s - 1; i >= 0; i--)
        begin
            if (plan_set[i])
            begin
                below = plan_time[i];
                break;
            end
        end
        for (int i = s + 1; i < DEPTH; i++)
        begin
            if (plan_set[i])
            begin
                above = plan_time[i];
                break;
            end
        end
        if (below > above)
            return below;
        span = {16'd0, above} - {16'd0, below} + 64'd1;
        r    = {$urandom, $urandom};
        return below + TIME_BITS'(r % span);
    endfunction

    // Asked time near a stored one, or at the extremes
    function automatic logic [TIME_BITS-1:0] pick_probe(int unsigned lo, int unsigned hi);
        int unsigned s;
        logic [TIME_BITS-1:0] v;
        s = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
        v = plan_time[s];
        case ($urandom_range(0, 7))
            0, 1, 2: return v;
            3:       return (v != 0) ? v - 1 : v;
            4:       return (v != TIME_TOP) ? v + 1 : v;
            5:       return '0;
            6:       return TIME_TOP;
            default: return rand_time();
        endcase
    endfunction

    task automatic push_load(int unsigned s, logic [TIME_BITS-1:0] t);
        tirs_query_t q;
        q.cmd        = CMD_LOAD;
        q.slot       = SLOT_W'(s);
        q.time_value = t;
        q.first_slot = SLOT_W'($urandom);
        q.last_slot  = SLOT_W'($urandom);
        feed_q.push_back(q);
        plan_time[s] = t;
        plan_set[s]  = 1'b1;
    endtask

    task automatic claim_slot(int unsigned s);
        if (!plan_set[s])
            push_load(s, fill_value(s));
    endtask

    // Load every slot the search will read, then queue the search word
    task automatic push_search(logic [CMD_W-1:0] op, logic [TIME_BITS-1:0] t,
                               int unsigned lo, int unsigned hi);
        tirs_query_t q;
        claim_slot(lo);
        claim_slot(hi);
        do
        begin
            first_gap = -1;
            void'(locate(1'b1, op, t, SLOT_W'(lo), SLOT_W'(hi)));
            if (first_gap >= 0)
                push_load(first_gap, fill_value(first_gap));
        end
        while (first_gap >= 0);
        q.cmd        = op;
        q.slot       = SLOT_W'($urandom);
        q.time_value = t;
        q.first_slot = SLOT_W'(lo);
        q.last_slot  = SLOT_W'(hi);
        feed_q.push_back(q);
    endtask

    // Drive query words; apply loads and predict answers as words are taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid <= 1'b0;
            query       <= '0;
            send_pause  <= 0;
            send_calm   <= 1'b0;
        end
        else
        begin
            if (query_valid && !query_stall)
            begin
                taken_count++;
                if (query.cmd == CMD_LOAD)
                begin
                    if (query.slot < DEPTH)
                        stamp_mem[query.slot] = query.time_value;
                end
                else if (query.cmd == CMD_FIRST || query.cmd == CMD_LAST)
                begin
                    answer_due_q.push_back(locate(1'b0, query.cmd, query.time_value,
                                                  query.first_slot, query.last_slot));
                end
            end
            if ($urandom_range(0, 149) == 0)
                send_calm <= !send_calm;
            // present the next word once the current one is gone
            if (!query_valid || !query_stall)
            begin
                if (send_pause > 0)
                begin
                    query_valid <= 1'b0;
                    send_pause  <= send_pause - 1;
                end
                else if (feed_q.size() != 0)
                begin
                    query       <= feed_q.pop_front();
                    query_valid <= 1'b1;
                    send_pause  <= pick_pause(send_calm);
                end
                else
                begin
                    query_valid <= 1'b0;
                end
            end
        end
    end

    // Take answer words, compare against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_stall <= 1'b0;
            hold_left    <= 0;
            hold_calm    <= 1'b0;
        end
        else
        begin
            if (answer_valid && !answer_stall)
            begin
                if (answer_due_q.size() == 0)
                begin
                    flag_mismatch($sformatf("answer found=%0b slot=%0d with none pending",
                                            answer.found, answer.found_slot));
                end
                else
                begin
                    due_answer = answer_due_q.pop_front();
                    if (answer.found !== due_answer.found)
                        flag_mismatch($sformatf("found %0b, predicted %0b",
                                                answer.found, due_answer.found));
                    if (answer.found_slot !== due_answer.found_slot)
                        flag_mismatch($sformatf("found_slot %0d, predicted %0d",
                                                answer.found_slot, due_answer.found_slot));
                end
            end
            if ($urandom_range(0, 149) == 0)
                hold_calm <= !hold_calm;
            if (hold_left > 0)
            begin
                answer_stall <= 1'b1;
                hold_left    <= hold_left - 1;
            end
            else
            begin
                answer_stall <= 1'b0;
                hold_left    <= pick_pause(hold_calm);
            end
        end
    end

    // Abort when neither side moves a word for too long
    always @(posedge clk)
    begin
        if ((query_valid && !query_stall) || (answer_valid && !answer_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("time_index_range_search_unit test failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned base, len, lo, hi, n, tmp;
        int r;
        logic [TIME_BITS-1:0] t, step;
        logic [CMD_W-1:0] op;
        tirs_query_t q;

        // Directed: duplicates, extremes, misses, inverted and single-slot ranges
        push_load(0, '0);
        push_load(1, 48'd40);
        push_load(2, 48'd40);
        push_load(3, 48'd40);
        push_load(4, 48'd900);
        push_load(5, TIME_TOP);
        push_load(DEPTH - 1, TIME_TOP);
        push_search(CMD_FIRST, '0, 0, 5);
        push_search(CMD_FIRST, 48'd40, 0, 5);
        push_search(CMD_LAST, 48'd40, 0, 5);
        push_search(CMD_FIRST, 48'd41, 0, 4);
        push_search(CMD_FIRST, 48'd901, 0, 4);
        push_search(CMD_LAST, 48'd39, 1, 4);
        push_search(CMD_LAST, TIME_TOP, 0, 5);
        push_search(CMD_FIRST, TIME_TOP, 0, 5);
        push_search(CMD_FIRST, 48'd40, 4, 1);
        push_search(CMD_LAST, 48'd40, 3, 3);
        push_search(CMD_FIRST, 48'd41, 3, 3);
        q            = '0;
        q.cmd        = CMD_UNUSED;
        q.time_value = rand_time();
        feed_q.push_back(q);
        push_search(CMD_FIRST, 48'd900, 0, DEPTH - 1);
        push_search(CMD_LAST, 48'd900, 0, DEPTH - 1);

        // Random: ascending regions with searches, wide searches, and noise
        while (feed_q.size() < STIM_TOTAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 160)
                                                   : $urandom_range(1, 32);
                base = $urandom_range(0, DEPTH - len);
                t    = ($urandom_range(0, 7) == 0) ? '0 : rand_time() >> $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                begin
                    push_load(base + i, t);
                    case ($urandom_range(0, 3))
                        0:       step = '0;
                        1, 2:    step = TIME_BITS'($urandom_range(1, 50));
                        default: step = rand_time() >> 20;
                    endcase
                    t = (TIME_TOP - t < step) ? TIME_TOP : t + step;
                end
                n = $urandom_range(3, 8);
                for (int i = 0; i < n; i++)
                begin
                    lo = $urandom_range(base, base + len - 1);
                    hi = $urandom_range(lo, base + len - 1);
                    if (lo != hi && $urandom_range(0, 9) == 0)
                    begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    op = $urandom_range(0, 1) ? CMD_FIRST : CMD_LAST;
                    push_search(op, pick_probe(lo, hi), lo, hi);
                end
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    lo = 0;
                    hi = DEPTH - 1;
                end
                else
                begin
                    lo = $urandom_range(0, DEPTH - 1);
                    hi = $urandom_range(0, DEPTH - 1);
                    if (lo > hi)
                    begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
                claim_slot(lo);
                claim_slot(hi);
                op = $urandom_range(0, 1) ? CMD_FIRST : CMD_LAST;
                push_search(op, pick_probe(lo, hi), lo, hi);
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: push_load($urandom_range(0, DEPTH - 1), rand_time());
                        1:
                        begin
                            q            = '0;
                            q.cmd        = CMD_UNUSED;
                            q.slot       = SLOT_W'($urandom);
                            q.time_value = rand_time();
                            q.first_slot = SLOT_W'($urandom);
                            q.last_slot  = SLOT_W'($urandom);
                            feed_q.push_back(q);
                        end
                        2:
                        begin
                            lo = $urandom_range(1, DEPTH - 1);
                            hi = $urandom_range(0, lo - 1);
                            op = $urandom_range(0, 1) ? CMD_FIRST : CMD_LAST;
                            push_search(op, rand_time(), lo, hi);
                        end
                        default:
                        begin
                            lo = $urandom_range(0, DEPTH - 1);
                            hi = $urandom_range(0, DEPTH - 1);
                            op = $urandom_range(0, 1) ? CMD_FIRST : CMD_LAST;
                            push_search(op, rand_time(), lo, hi);
                        end
                    endcase
                end
            end
        end
        total_count = feed_q.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hold until every word is taken and every answer is back, then drain
        while (taken_count != total_count || answer_due_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (error_count == 0)
            $display("time_index_range_search_unit test passed");
        else
            $display("time_index_range_search_unit test failed");
        $finish;
    end

endmodule
